// ===== hdl/bspe_pkg.sv =====
// package with widths, request codes and helpers of the cubic b-spline point evaluator
`timescale 1ns / 1ps
`default_nettype none
package bspe_pkg;
  localparam int CTRL_DEPTH = 64;
  localparam int KNOT_DEPTH = CTRL_DEPTH + 4;
  localparam int IDX_W      = 7;
  localparam int KNOT_W     = 17;
  localparam int COORD_W    = 32;
  localparam int RATIO_W    = 16;
  localparam int SPAN_W     = 6;
  localparam int CFG_W      = 7;
  localparam int REQ_W      = 2;
  localparam int QUO_W      = 47;

  localparam logic [REQ_W-1:0] REQ_KNOT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POINT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EVAL  = 2'd2;

  localparam logic signed [17:0] KNOT_EPS  = 18'sd66;
  localparam logic signed [31:0] BASIS_ONE = 32'sd1073741824;
  localparam logic signed [48:0] ACC_ONE   = 49'sd1073741824;
  localparam logic signed [48:0] ACC_MONE  = -49'sd1073741824;

  typedef logic signed [31:0] basis_t;
  typedef logic [KNOT_W-1:0]  knot_t;

  // round half up from q2.30 weighted sum to q16.16 and saturate
  function automatic logic signed [31:0] round_sat(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = (v + 66'sd536870912) >>> 30;
    if (r > 66'sd2147483647) begin
      round_sat = 32'sh7fffffff;
    end else if (r < -66'sd2147483648) begin
      round_sat = 32'sh80000000;
    end else begin
      round_sat = r[31:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== hdl/bspe_if.sv =====
// item channel interfaces of the cubic b-spline point evaluator
`timescale 1ns / 1ps
`default_nettype none
interface bspe_in_if;
  import bspe_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [IDX_W-1:0]           entry_index;
  logic [KNOT_W-1:0]          knot_value;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic [RATIO_W-1:0]         ratio;
  modport source (output valid, req_type, entry_index, knot_value, point_x, point_y, ratio,
                  input ready);
  modport sink (input valid, req_type, entry_index, knot_value, point_x, point_y, ratio,
                output ready);
endinterface

interface bspe_out_if;
  import bspe_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  curve_x;
  logic signed [COORD_W-1:0]  curve_y;
  logic [SPAN_W-1:0]          span_index;
  modport source (output valid, curve_x, curve_y, span_index, input ready);
  modport sink (input valid, curve_x, curve_y, span_index, output ready);
endinterface
`default_nettype wire

// ===== hdl/cubic_bspline_point_eval_top.sv =====
// cubic b-spline point evaluator: knot/point tables, span search, cox-de boor, weighted sum
// write items give no result; an evaluate item runs a span search, a knot load and level 0,
// one division on the 47-step restoring divider shared by all terms for each nonzero basis
// term, a skip for each skipped term, 24 basis stores and the weighted sum; one item at a time
// synchronous active-low reset clears control and sets num_control_points to 4
`timescale 1ns / 1ps
`default_nettype none
module cubic_bspline_point_eval_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [bspe_pkg::CFG_W-1:0]   cfg_wr_data,
  bspe_in_if.sink                           in_item,
  bspe_out_if.source                        out_item
);
  import bspe_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SRD   = 4'd1;
  localparam logic [3:0] ST_SCMP  = 4'd2;
  localparam logic [3:0] ST_LOAD  = 4'd3;
  localparam logic [3:0] ST_LVL0  = 4'd4;
  localparam logic [3:0] ST_TERM  = 4'd5;
  localparam logic [3:0] ST_DLOAD = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_DEND  = 4'd8;
  localparam logic [3:0] ST_STORE = 4'd9;
  localparam logic [3:0] ST_PRD   = 4'd10;
  localparam logic [3:0] ST_PMX   = 4'd11;
  localparam logic [3:0] ST_PMY   = 4'd12;
  localparam logic [3:0] ST_PACC  = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  knot_t                knot_mem [KNOT_DEPTH];
  logic [COORD_W-1:0]   cx_mem [CTRL_DEPTH];
  logic [COORD_W-1:0]   cy_mem [CTRL_DEPTH];

  logic [3:0]           state_r;
  logic [CFG_W-1:0]     ncp_r;
  logic [IDX_W-1:0]     n_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SPAN_W-1:0]    s_r;
  logic [1:0]           lvl_r;
  logic [2:0]           j_r;
  logic                 tsel_r;
  logic [5:0]           cnt_r;
  logic                 out_valid_r;

  logic [RATIO_W-1:0]   t_r;
  knot_t                kv_r [8];
  basis_t               nb_r [8];
  logic signed [48:0]   acc_r;
  logic [QUO_W-1:0]     dvd_r;
  logic [KNOT_W-1:0]    rem_r;
  logic [KNOT_W-1:0]    dvs_r;
  logic                 neg_r;
  logic signed [63:0]   prod_r;
  logic signed [65:0]   sx_r;
  logic signed [65:0]   sy_r;
  knot_t                knot_rd_r;
  logic signed [COORD_W-1:0] cx_rd_r;
  logic signed [COORD_W-1:0] cy_rd_r;
  logic signed [COORD_W-1:0] ox_r;
  logic signed [COORD_W-1:0] oy_r;
  logic [SPAN_W-1:0]    os_r;

  logic                 accept;
  logic [IDX_W-1:0]     n_clamp;
  logic [IDX_W-1:0]     knot_raddr;
  logic [SPAN_W-1:0]    ctrl_raddr;
  logic                 t_below;
  logic [IDX_W-1:0]     s_cand;
  logic [IDX_W-1:0]     s_clamp;
  logic signed [17:0]   t_s;
  logic signed [17:0]   kv0_s, kv1_s, kvk_s, kvk1_s;
  logic signed [17:0]   term_a;
  logic signed [17:0]   term_b;
  basis_t               term_nv;
  logic                 pass;
  logic                 term_zero;
  logic signed [31:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic [63:0]          prod_mag;
  logic [17:0]          rem_sh;
  logic                 rem_ge;
  logic [17:0]          rem_sub;
  logic signed [48:0]   quo_s;
  basis_t               nb_new;
  logic                 out_load;

  assign accept         = in_item.valid && in_item.ready;
  assign in_item.ready  = (state_r == ST_IDLE);
  assign out_item.valid = out_valid_r;
  assign out_item.curve_x    = ox_r;
  assign out_item.curve_y    = oy_r;
  assign out_item.span_index = os_r;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_item.ready);

  always_comb begin
    if (ncp_r < 7'd4) begin
      n_clamp = 7'd4;
    end else if (ncp_r > 7'(CTRL_DEPTH)) begin
      n_clamp = 7'(CTRL_DEPTH);
    end else begin
      n_clamp = ncp_r;
    end
  end

  assign knot_raddr = (state_r == ST_LOAD) ? ({1'b0, s_r} - 7'd3 + {4'd0, idx_r[2:0]}) : idx_r;
  assign ctrl_raddr = s_r - 6'd3 + {4'd0, j_r[1:0]};

  // span search
  assign t_below = {1'b0, t_r} < knot_rd_r;
  assign s_cand  = t_below ? (idx_r - 7'd1) : (n_r + 7'd2);
  always_comb begin
    if (s_cand < 7'd3) begin
      s_clamp = 7'd3;
    end else if (s_cand > n_r - 7'd1) begin
      s_clamp = n_r - 7'd1;
    end else begin
      s_clamp = s_cand;
    end
  end

  // term operands, position 0 of the rotating rows is the current basis index
  assign t_s   = {2'b00, t_r};
  assign kv0_s = {1'b0, kv_r[0]};
  assign kv1_s = {1'b0, kv_r[1]};
  always_comb begin
    case (lvl_r)
      2'd1: begin
        kvk_s  = {1'b0, kv_r[1]};
        kvk1_s = {1'b0, kv_r[2]};
      end
      2'd2: begin
        kvk_s  = {1'b0, kv_r[2]};
        kvk1_s = {1'b0, kv_r[3]};
      end
      default: begin
        kvk_s  = {1'b0, kv_r[3]};
        kvk1_s = {1'b0, kv_r[4]};
      end
    endcase
  end
  assign term_a    = tsel_r ? (kvk1_s - t_s) : (t_s - kv0_s);
  assign term_b    = tsel_r ? (kvk1_s - kv1_s) : (kvk_s - kv0_s);
  assign term_nv   = tsel_r ? nb_r[1] : nb_r[0];
  assign pass      = ({1'b0, j_r} + {2'b00, lvl_r}) > 4'd6;
  assign term_zero = pass || (term_b < KNOT_EPS) || (term_nv == 32'sd0);

  // shared multiplier
  always_comb begin
    case (state_r)
      ST_PMX: begin
        mul_a = cx_rd_r;
        mul_b = nb_r[0];
      end
      ST_PMY: begin
        mul_a = cy_rd_r;
        mul_b = nb_r[0];
      end
      default: begin
        mul_a = {{14{term_a[17]}}, term_a};
        mul_b = term_nv;
      end
    endcase
  end

  assign prod_mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign rem_sh   = {rem_r, dvd_r[QUO_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvs_r};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign quo_s    = neg_r ? -$signed({2'b00, dvd_r}) : $signed({2'b00, dvd_r});

  always_comb begin
    if (pass) begin
      nb_new = nb_r[0];
    end else if (acc_r > ACC_ONE) begin
      nb_new = BASIS_ONE;
    end else if (acc_r < ACC_MONE) begin
      nb_new = -BASIS_ONE;
    end else begin
      nb_new = acc_r[31:0];
    end
  end

  // tables
  always_ff @(posedge clk) begin
    if (accept && in_item.req_type == REQ_KNOT && in_item.entry_index < 7'(KNOT_DEPTH)) begin
      knot_mem[in_item.entry_index] <= in_item.knot_value;
    end
    if (accept && in_item.req_type == REQ_POINT && in_item.entry_index < 7'(CTRL_DEPTH)) begin
      cx_mem[in_item.entry_index[SPAN_W-1:0]] <= in_item.point_x;
      cy_mem[in_item.entry_index[SPAN_W-1:0]] <= in_item.point_y;
    end
    knot_rd_r <= knot_mem[knot_raddr];
    cx_rd_r   <= cx_mem[ctrl_raddr];
    cy_rd_r   <= cy_mem[ctrl_raddr];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ncp_r       <= 7'd4;
      n_r         <= 7'd4;
      idx_r       <= '0;
      s_r         <= 6'd3;
      lvl_r       <= 2'd1;
      j_r         <= '0;
      tsel_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ncp_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && in_item.req_type == REQ_EVAL) begin
            n_r     <= n_clamp;
            idx_r   <= 7'd3;
            state_r <= ST_SRD;
          end
        end
        ST_SRD: begin
          state_r <= ST_SCMP;
        end
        ST_SCMP: begin
          if (t_below || idx_r == n_r + 7'd1) begin
            s_r     <= s_clamp[SPAN_W-1:0];
            idx_r   <= '0;
            state_r <= ST_LOAD;
          end else begin
            idx_r   <= idx_r + 7'd1;
            state_r <= ST_SRD;
          end
        end
        ST_LOAD: begin
          if (idx_r == 7'd8) begin
            state_r <= ST_LVL0;
          end else begin
            idx_r <= idx_r + 7'd1;
          end
        end
        ST_LVL0: begin
          lvl_r   <= 2'd1;
          j_r     <= '0;
          tsel_r  <= 1'b0;
          state_r <= ST_TERM;
        end
        ST_TERM: begin
          if (!term_zero) begin
            state_r <= ST_DLOAD;
          end else if (!tsel_r) begin
            tsel_r <= 1'b1;
          end else begin
            state_r <= ST_STORE;
          end
        end
        ST_DLOAD: begin
          cnt_r   <= 6'(QUO_W);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= ST_DEND;
          end
        end
        ST_DEND: begin
          if (!tsel_r) begin
            tsel_r  <= 1'b1;
            state_r <= ST_TERM;
          end else begin
            state_r <= ST_STORE;
          end
        end
        ST_STORE: begin
          tsel_r <= 1'b0;
          if (j_r == 3'd7) begin
            j_r <= '0;
            if (lvl_r == 2'd3) begin
              state_r <= ST_PRD;
            end else begin
              lvl_r   <= lvl_r + 2'd1;
              state_r <= ST_TERM;
            end
          end else begin
            j_r     <= j_r + 3'd1;
            state_r <= ST_TERM;
          end
        end
        ST_PRD: begin
          state_r <= ST_PMX;
        end
        ST_PMX: begin
          state_r <= ST_PMY;
        end
        ST_PMY: begin
          state_r <= ST_PACC;
        end
        ST_PACC: begin
          if (j_r == 3'd3) begin
            state_r <= ST_OUT;
          end else begin
            j_r     <= j_r + 3'd1;
            state_r <= ST_PRD;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          t_r <= in_item.ratio;
        end
      end
      ST_LOAD: begin
        if (idx_r != 7'd0) begin
          for (int i = 0; i < 7; i++) begin
            kv_r[i] <= kv_r[i+1];
          end
          kv_r[7] <= knot_rd_r;
        end
      end
      ST_LVL0: begin
        for (int i = 0; i < 7; i++) begin
          nb_r[i] <= ({1'b0, t_r} >= kv_r[i] && {1'b0, t_r} < kv_r[i+1]) ? BASIS_ONE : 32'sd0;
        end
        nb_r[7] <= 32'sd0;
        acc_r   <= '0;
      end
      ST_DLOAD: begin
        neg_r <= prod_r[63];
        dvd_r <= prod_mag[QUO_W-1:0];
        rem_r <= '0;
        dvs_r <= term_b[KNOT_W-1:0];
      end
      ST_DIV: begin
        rem_r <= rem_ge ? rem_sub[KNOT_W-1:0] : rem_sh[KNOT_W-1:0];
        dvd_r <= {dvd_r[QUO_W-2:0], rem_ge};
      end
      ST_DEND: begin
        acc_r <= acc_r + quo_s;
      end
      ST_STORE: begin
        for (int i = 0; i < 7; i++) begin
          nb_r[i] <= nb_r[i+1];
          kv_r[i] <= kv_r[i+1];
        end
        nb_r[7] <= nb_new;
        kv_r[7] <= kv_r[0];
        acc_r   <= '0;
        if (j_r == 3'd7 && lvl_r == 2'd3) begin
          sx_r <= '0;
          sy_r <= '0;
        end
      end
      ST_PMY: begin
        sx_r <= sx_r + {{2{prod_r[63]}}, prod_r};
      end
      ST_PACC: begin
        sy_r <= sy_r + {{2{prod_r[63]}}, prod_r};
        for (int i = 0; i < 7; i++) begin
          nb_r[i] <= nb_r[i+1];
        end
        nb_r[7] <= nb_r[0];
      end
      ST_OUT: begin
        if (out_load) begin
          ox_r <= round_sat(sx_r);
          oy_r <= round_sat(sy_r);
          os_r <= s_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_busy_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.req_type == REQ_EVAL) |=> !in_item.ready)
    else $error("ready during evaluation");

  a_basis_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TERM) |-> (nb_r[0] <= BASIS_ONE && nb_r[0] >= -BASIS_ONE))
    else $error("basis value out of range");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r != 6'd0))
    else $error("divider count underflow");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_item.valid && out_item.span_index >= 6'd3))
    else $error("result not presented");
endmodule
`default_nettype wire
